[src/kaps_pkg.sv]
// ----------------------------------------------------------------------------
// kaps_pkg: shared types and constants for the knee/ankle target shaper
// Register map codes, divider sizing, pipeline latencies and the structs
// that travel between the front end, the dividers and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package kaps_pkg;

  // register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_RATIO  = 2'd0;
  localparam logic [1:0] REG_OFFSET = 2'd1;
  localparam logic [1:0] REG_KREV   = 2'd2;
  localparam logic [1:0] REG_AREV   = 2'd3;

  localparam logic [15:0]        RATIO_RST  = 16'd8192;
  localparam logic signed [15:0] OFFSET_RST = -16'sd2437;

  // divider: dividend/divisor word and saturated quotient magnitude bits
  localparam int DIV_W  = 72;
  localparam int DIV_QB = 19;
  localparam int DIV_LAT = DIV_QB + 1;

  // front end register stages, then divider, then output register
  localparam int FRONT_LAT = 6;
  localparam int OUT_LAT   = FRONT_LAT + DIV_LAT + 1;

  typedef struct packed {
    logic [15:0]        ratio;
    logic signed [15:0] offset;
    logic               knee_rev;
    logic               ankle_rev;
  } cfg_t;

  // per-item values that bypass the dividers
  typedef struct packed {
    logic signed [16:0] mk;
    logic signed [17:0] base_a;
    logic               sk;
    logic               sa;
    logic [15:0]        rk;
    logic [15:0]        ra;
    logic               flt_k;
    logic               flt_a;
  } side_t;

  // rounding divide request: floor(mag / dvs), sign applied afterwards
  typedef struct packed {
    logic [DIV_W-1:0] mag;
    logic [DIV_W-1:0] dvs;
    logic             neg;
  } div_req_t;

endpackage

`default_nettype wire

[src/kaps_front.sv]
// ----------------------------------------------------------------------------
// kaps_front: sign removal, linkage mapping and torque numerators
// Six register stages: capture, first products, second products, sums,
// rounding numerators, sign/magnitude split for the dividers.
// ----------------------------------------------------------------------------
`default_nettype none

module kaps_front (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     valid_i,
  input  wire kaps_pkg::cfg_t           cfg_i,
  input  wire logic signed [15:0]       knee_goal_i,
  input  wire logic signed [15:0]       ankle_goal_i,
  input  wire logic [15:0]              knee_stiffness_i,
  input  wire logic [15:0]              knee_damping_i,
  input  wire logic [15:0]              ankle_stiffness_i,
  input  wire logic [15:0]              ankle_damping_i,
  input  wire logic signed [15:0]       knee_motor_pos_i,
  input  wire logic signed [15:0]       knee_motor_vel_i,
  input  wire logic signed [15:0]       ankle_motor_pos_i,
  input  wire logic signed [15:0]       ankle_motor_vel_i,
  output logic                          valid_o,
  output kaps_pkg::side_t               side_o,
  output kaps_pkg::div_req_t            kreq_o,
  output kaps_pkg::div_req_t            areq_o
);

  localparam int W = kaps_pkg::DIV_W;
  localparam int NS = kaps_pkg::FRONT_LAT;

  logic [NS-1:0]   vld_q;
  kaps_pkg::side_t side_q [NS];
  kaps_pkg::side_t side_d;

  // stage A: captured, signs removed
  logic signed [15:0] a_qk_q, a_qa_q, a_ko_q;
  logic [15:0]        a_r_q, a_kpk_q, a_kdk_q, a_kpa_q, a_kda_q;
  logic signed [16:0] a_mk_q, a_dmk_q, a_ma_q, a_dma_q;
  logic signed [16:0] mk_d, dmk_d, ma_d, dma_d;

  // stage B
  logic signed [35:0] b_ek_q;
  logic signed [18:0] b_ea_q;
  logic [31:0]        b_kpr_q, b_kdr_q, b_rr_q;
  logic [16:0]        b_ksum_q, b_kdsum_q;
  logic signed [33:0] b_p_q;
  logic [15:0]        b_kpk_q, b_kpa_q, b_kda_q;
  logic signed [16:0] b_dmk_q, b_dma_q;

  // stage C
  logic signed [52:0] c_t1_q;
  logic signed [50:0] c_t2_q;
  logic signed [46:0] c_t3_q;
  logic signed [48:0] c_t4_q;
  logic [47:0]        c_den_q;
  logic signed [65:0] c_prr_q;
  logic signed [45:0] c_na1_q;
  logic signed [51:0] c_na2_q;
  logic [31:0]        c_da_q;

  // stage D
  logic signed [55:0] d_t_q;
  logic signed [52:0] d_na_q;
  logic signed [65:0] d_prr_q;
  logic [47:0]        d_den_q;
  logic [31:0]        d_da_q;

  // stage E: numerators 2N + D and divisors 2D
  logic signed [W-1:0] e_nk_q, e_na_q;
  logic [W-1:0]        e_dk_q, e_da_q;

  // stage F
  kaps_pkg::div_req_t f_kreq_q, f_areq_q;
  logic [W-1:0]       nk_u, na_u;

  // undo motor direction and collect bypass values
  always_comb begin
    mk_d  = cfg_i.knee_rev  ? -17'(knee_motor_pos_i)  : 17'(knee_motor_pos_i);
    dmk_d = cfg_i.knee_rev  ? -17'(knee_motor_vel_i)  : 17'(knee_motor_vel_i);
    ma_d  = cfg_i.ankle_rev ? -17'(ankle_motor_pos_i) : 17'(ankle_motor_pos_i);
    dma_d = cfg_i.ankle_rev ? -17'(ankle_motor_vel_i) : 17'(ankle_motor_vel_i);
    side_d.mk     = mk_d;
    side_d.base_a = 18'(knee_goal_i) + 18'(ankle_goal_i) - 18'(cfg_i.offset);
    side_d.sk     = cfg_i.knee_rev;
    side_d.sa     = cfg_i.ankle_rev;
    side_d.rk     = knee_motor_pos_i;
    side_d.ra     = ankle_motor_pos_i;
    side_d.flt_k  = (knee_stiffness_i == 16'd0) || (cfg_i.ratio == 16'd0);
    side_d.flt_a  = (ankle_stiffness_i == 16'd0) || (cfg_i.ratio == 16'd0);
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NS-2:0], valid_i};
    end
  end

  // bypass line
  always_ff @(posedge clk_i) begin
    side_q[0] <= side_d;
    for (int i = 1; i < NS; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  // datapath stages
  always_ff @(posedge clk_i) begin
    // A
    a_qk_q  <= knee_goal_i;
    a_qa_q  <= ankle_goal_i;
    a_ko_q  <= cfg_i.offset;
    a_r_q   <= cfg_i.ratio;
    a_kpk_q <= knee_stiffness_i;
    a_kdk_q <= knee_damping_i;
    a_kpa_q <= ankle_stiffness_i;
    a_kda_q <= ankle_damping_i;
    a_mk_q  <= mk_d;
    a_dmk_q <= dmk_d;
    a_ma_q  <= ma_d;
    a_dma_q <= dma_d;
    // B: position errors and gain products
    b_ek_q    <= 36'($signed({1'b0, a_r_q}) * (36'(a_qk_q) - 36'(a_ko_q)))
               + ((36'(a_ko_q) - 36'(a_mk_q)) <<< 12);
    b_ea_q    <= 19'(a_qk_q) + 19'(a_qa_q) - 19'(a_ko_q) - 19'(a_ma_q);
    b_kpr_q   <= 32'(a_kpa_q) * 32'(a_r_q);
    b_kdr_q   <= 32'(a_kda_q) * 32'(a_r_q);
    b_rr_q    <= 32'(a_r_q) * 32'(a_r_q);
    b_ksum_q  <= 17'(a_kpk_q) + 17'(a_kpa_q);
    b_kdsum_q <= 17'(a_kdk_q) + 17'(a_kda_q);
    b_p_q     <= 34'($signed({1'b0, a_kdk_q}) * a_dmk_q);
    b_kpk_q   <= a_kpk_q;
    b_kpa_q   <= a_kpa_q;
    b_kda_q   <= a_kda_q;
    b_dmk_q   <= a_dmk_q;
    b_dma_q   <= a_dma_q;
    // C: torque terms and denominators
    c_t1_q  <= 53'($signed({1'b0, b_ksum_q}) * b_ek_q);
    c_t2_q  <= 51'($signed({1'b0, b_kpr_q}) * b_ea_q);
    c_t3_q  <= 47'($signed({1'b0, b_kdsum_q}) * b_dmk_q) <<< 12;
    c_t4_q  <= 49'($signed({1'b0, b_kdr_q}) * b_dma_q);
    c_den_q <= 48'(b_rr_q) * 48'(b_kpk_q);
    c_prr_q <= 66'(b_p_q * $signed({1'b0, b_rr_q}));
    c_na1_q <= 46'($signed({1'b0, b_kda_q}) * b_dmk_q) <<< 12;
    c_na2_q <= 52'($signed({1'b0, b_kpa_q}) * b_ek_q);
    c_da_q  <= b_kpr_q;
    // D: sums
    d_t_q   <= 56'(c_t1_q) - 56'(c_t2_q) - 56'(c_t3_q) + 56'(c_t4_q);
    d_na_q  <= 53'(c_na1_q) - 53'(c_na2_q);
    d_prr_q <= c_prr_q;
    d_den_q <= c_den_q;
    d_da_q  <= c_da_q;
    // E: round-half-up numerators
    e_nk_q <= (W'(d_t_q) <<< 13) + (W'(d_prr_q) <<< 1) + W'($signed({1'b0, d_den_q}));
    e_dk_q <= W'(d_den_q) << 1;
    e_na_q <= (W'(d_na_q) <<< 1) + W'($signed({1'b0, d_da_q}));
    e_da_q <= W'(d_da_q) << 1;
    // F: floor of a negative value via ceil of its magnitude
    f_kreq_q.neg <= e_nk_q[W-1];
    f_kreq_q.mag <= e_nk_q[W-1] ? (~nk_u + e_dk_q) : nk_u;
    f_kreq_q.dvs <= e_dk_q;
    f_areq_q.neg <= e_na_q[W-1];
    f_areq_q.mag <= e_na_q[W-1] ? (~na_u + e_da_q) : na_u;
    f_areq_q.dvs <= e_da_q;
  end

  assign nk_u    = e_nk_q;
  assign na_u    = e_na_q;
  assign valid_o = vld_q[NS-1];
  assign side_o  = side_q[NS-1];
  assign kreq_o  = f_kreq_q;
  assign areq_o  = f_areq_q;

endmodule

`default_nettype wire

[src/kaps_sdiv.sv]
// ----------------------------------------------------------------------------
// kaps_sdiv: pipelined saturating restoring divider
// One overflow check stage, then one quotient bit per stage. The quotient
// magnitude saturates at all ones and the sign is applied at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module kaps_sdiv (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           valid_i,
  input  wire kaps_pkg::div_req_t             req_i,
  output logic                                valid_o,
  output logic signed [kaps_pkg::DIV_QB:0]    quot_o
);

  localparam int W  = kaps_pkg::DIV_W;
  localparam int QB = kaps_pkg::DIV_QB;

  logic [QB:0]   vld_q;
  logic [QB:0]   neg_q;
  logic [QB:0]   ovf_q;
  logic [W-1:0]  rem_q [QB+1];
  logic [W-1:0]  dvs_q [QB+1];
  logic [QB-1:0] qt_q  [QB+1];
  logic [W-1:0]  dsh   [QB];
  logic [QB-1:0] ge;
  logic [QB-1:0] qmag;

  // trial subtract per stage
  always_comb begin
    for (int k = 1; k <= QB; k++) begin
      dsh[k-1] = dvs_q[k-1] << (QB - k);
      ge[k-1]  = rem_q[k-1] >= dsh[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[QB-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= req_i.mag;
    dvs_q[0] <= req_i.dvs;
    neg_q[0] <= req_i.neg;
    ovf_q[0] <= req_i.mag >= (req_i.dvs << QB);
    qt_q[0]  <= '0;
    for (int k = 1; k <= QB; k++) begin
      rem_q[k] <= ge[k-1] ? (rem_q[k-1] - dsh[k-1]) : rem_q[k-1];
      dvs_q[k] <= dvs_q[k-1];
      neg_q[k] <= neg_q[k-1];
      ovf_q[k] <= ovf_q[k-1];
      qt_q[k]  <= qt_q[k-1] | (ge[k-1] ? (QB'(1) << (QB - k)) : '0);
    end
  end

  // saturate and sign
  assign qmag    = ovf_q[QB] ? '1 : qt_q[QB];
  assign quot_o  = neg_q[QB] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
  assign valid_o = vld_q[QB];

`ifndef SYNTHESIS
  a_rem_below_dvs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[QB] && !ovf_q[QB] |-> rem_q[QB] < dvs_q[QB])
    else $error("divider remainder not below divisor");
`endif

endmodule

`default_nettype wire

[src/knee_ankle_pd_target_shaping.sv]
// ----------------------------------------------------------------------------
// knee_ankle_pd_target_shaping: coupled knee/ankle PD position targets
// A started item passes the front end, the dividers and an output register to done_o.
// Throughput: one item per cycle; busy stays low, the pipeline never stalls.
// The dividers have 20 stages each: an overflow check, then one
// quotient bit per stage for 19 bits.
// Reset clears the valid bits and loads register defaults; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module knee_ankle_pd_target_shaping (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] knee_goal_i,
  input  wire logic signed [15:0] ankle_goal_i,
  input  wire logic [15:0]        knee_stiffness_i,
  input  wire logic [15:0]        knee_damping_i,
  input  wire logic [15:0]        ankle_stiffness_i,
  input  wire logic [15:0]        ankle_damping_i,
  input  wire logic signed [15:0] knee_motor_pos_i,
  input  wire logic signed [15:0] knee_motor_vel_i,
  input  wire logic signed [15:0] ankle_motor_pos_i,
  input  wire logic signed [15:0] ankle_motor_vel_i,
  output logic                    done_o,
  output logic signed [15:0]      knee_motor_target_o,
  output logic signed [15:0]      ankle_motor_target_o,
  output logic                    gain_fault_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int QB = kaps_pkg::DIV_QB;
  localparam int DL = kaps_pkg::DIV_LAT;

  kaps_pkg::cfg_t     cfg_q;
  logic               wr_en;
  logic               fr_vld;
  kaps_pkg::side_t    fr_side;
  kaps_pkg::div_req_t kreq, areq;
  logic               kdiv_vld, adiv_vld;
  logic signed [QB:0] kquot, aquot;
  kaps_pkg::side_t    side_q [DL];
  kaps_pkg::side_t    sd;
  logic signed [20:0] vk, va;
  logic signed [21:0] tk, ta;
  logic [16:0]        satk, sata;
  logic               done_q, fault_d, fault_q;
  logic signed [15:0] tk_d, ta_d, tk_q, ta_q;

  // saturate to 16 bits, flag in the top bit
  function automatic logic [16:0] sat16(input logic signed [21:0] v);
    logic [16:0] r;
    if (v > 22'sd32767) begin
      r = {1'b1, 16'h7fff};
    end else if (v < -22'sd32768) begin
      r = {1'b1, 16'h8000};
    end else begin
      r = {1'b0, v[15:0]};
    end
    return r;
  endfunction

  // configuration registers
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ratio     <= kaps_pkg::RATIO_RST;
      cfg_q.offset    <= kaps_pkg::OFFSET_RST;
      cfg_q.knee_rev  <= 1'b0;
      cfg_q.ankle_rev <= 1'b0;
    end else if (wr_en) begin
      case (paddr[3:2])
        kaps_pkg::REG_RATIO:  cfg_q.ratio     <= pwdata[15:0];
        kaps_pkg::REG_OFFSET: cfg_q.offset    <= pwdata[15:0];
        kaps_pkg::REG_KREV:   cfg_q.knee_rev  <= pwdata[0];
        kaps_pkg::REG_AREV:   cfg_q.ankle_rev <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      kaps_pkg::REG_RATIO:  prdata = {16'd0, cfg_q.ratio};
      kaps_pkg::REG_OFFSET: prdata = {16'd0, cfg_q.offset};
      kaps_pkg::REG_KREV:   prdata = {31'd0, cfg_q.knee_rev};
      kaps_pkg::REG_AREV:   prdata = {31'd0, cfg_q.ankle_rev};
      default:              prdata = '0;
    endcase
  end

  assign busy = 1'b0;

  kaps_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (start && !busy),
    .cfg_i             (cfg_q),
    .knee_goal_i       (knee_goal_i),
    .ankle_goal_i      (ankle_goal_i),
    .knee_stiffness_i  (knee_stiffness_i),
    .knee_damping_i    (knee_damping_i),
    .ankle_stiffness_i (ankle_stiffness_i),
    .ankle_damping_i   (ankle_damping_i),
    .knee_motor_pos_i  (knee_motor_pos_i),
    .knee_motor_vel_i  (knee_motor_vel_i),
    .ankle_motor_pos_i (ankle_motor_pos_i),
    .ankle_motor_vel_i (ankle_motor_vel_i),
    .valid_o           (fr_vld),
    .side_o            (fr_side),
    .kreq_o            (kreq),
    .areq_o            (areq)
  );

  kaps_sdiv u_kdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_vld),
    .req_i   (kreq),
    .valid_o (kdiv_vld),
    .quot_o  (kquot)
  );

  kaps_sdiv u_adiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_vld),
    .req_i   (areq),
    .valid_o (adiv_vld),
    .quot_o  (aquot)
  );

  // bypass values wait out the divider
  always_ff @(posedge clk_i) begin
    side_q[0] <= fr_side;
    for (int i = 1; i < DL; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  // final add, direction sign, saturation and zero-gain override
  always_comb begin
    sd   = side_q[DL-1];
    vk   = 21'(sd.mk) + 21'(kquot);
    va   = 21'(sd.base_a) + 21'(aquot);
    tk   = sd.sk ? -22'(vk) : 22'(vk);
    ta   = sd.sa ? -22'(va) : 22'(va);
    satk = sat16(tk);
    sata = sat16(ta);
    tk_d = sd.flt_k ? sd.rk : satk[15:0];
    ta_d = sd.flt_a ? sd.ra : sata[15:0];
    fault_d = sd.flt_k || sd.flt_a || (!sd.flt_k && satk[16]) || (!sd.flt_a && sata[16]);
  end

  // result beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= kdiv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    tk_q    <= tk_d;
    ta_q    <= ta_d;
    fault_q <= fault_d;
  end

  assign done_o               = done_q;
  assign knee_motor_target_o  = tk_q;
  assign ankle_motor_target_o = ta_q;
  assign gain_fault_o         = fault_q;

`ifndef SYNTHESIS
  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kdiv_vld == adiv_vld)
    else $error("knee and ankle dividers out of step");
  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##(kaps_pkg::OUT_LAT) done_o)
    else $error("result beat missing at fixed latency");
`endif

endmodule

`default_nettype wire
